// ===== rtl/core/mtgp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtgp_pkg
// Types and character codes shared by the meter telemetry group parser.
// ----------------------------------------------------------------------------
package mtgp_pkg;

  typedef enum logic [1:0] {
    ST_INIT = 2'd0,
    ST_WAIT = 2'd1,
    ST_READ = 2'd2
  } parse_state_e;

  typedef enum logic {
    OP_RX   = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  localparam logic [6:0] CH_STX   = 7'h02;
  localparam logic [6:0] CH_ETX   = 7'h03;
  localparam logic [6:0] CH_LF    = 7'h0A;
  localparam logic [6:0] CH_CR    = 7'h0D;
  localparam logic [6:0] SEP_STD  = 7'h09;
  localparam logic [6:0] SEP_HIST = 7'h20;

  localparam logic [5:0] SUM_MASK = 6'h3F;
  localparam logic [7:0] SUM_BIAS = 8'h20;

  typedef struct packed {
    logic       opcode;
    logic [7:0] rx_char;
    logic [6:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] link_state;
    logic       frame_done;
    logic       group_done;
    logic       group_ok;
    logic [7:0] group_length;
    logic       stamp_present;
    logic [7:0] stamp_start;
    logic       value_present;
    logic [7:0] value_start;
    logic [6:0] read_data;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/core/mtgp_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtgp_in_if
// Input channel: one character or one read request per transfer.
// ----------------------------------------------------------------------------
interface mtgp_in_if
  import mtgp_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mtgp_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtgp_out_if
// Result channel: parser status and read data, one per transfer.
// ----------------------------------------------------------------------------
interface mtgp_out_if
  import mtgp_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/mtgp_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mtgp_store
// Group character memory, one write and one registered read port, with
// forwarding of a write that lands in the same cycle as the read.
// ----------------------------------------------------------------------------
module mtgp_store #(
  parameter int DEPTH = 128,
  parameter int AW    = 7
) (
  input  wire logic          clk_i,
  input  wire logic          wr_en_i,
  input  wire logic [AW-1:0] wr_addr_i,
  input  wire logic [6:0]    wr_data_i,
  input  wire logic          rd_en_i,
  input  wire logic [6:0]    rd_addr_i,
  output logic      [6:0]    rd_data_o
);

  localparam int MW = (AW > 7) ? AW : 7;

  logic [6:0] mem [DEPTH];
  logic [6:0] rd_data_q;
  logic       fwd;

  assign fwd = wr_en_i && (MW'(wr_addr_i) == MW'(rd_addr_i));

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= fwd ? wr_data_i : mem[AW'(rd_addr_i)];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

// ===== rtl/core/meter_teleinfo_group_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
// an input transfer passes the input register and then the result register to out_if
// throughput: one item per cycle unless out_if stalls; the group store is read when
// an item is taken, written when the item before it is processed, with forwarding
// reset: rst_ni clears control state, counters and offsets at once; the group
// store is not cleared, entries at or beyond the fill count are never returned
// ----------------------------------------------------------------------------
// meter_teleinfo_group_parser
// Character parser for a meter telemetry stream: stores a group, checks its
// checksum on CR and reports field offsets; stored characters can be read back.
// ----------------------------------------------------------------------------
module meter_teleinfo_group_parser
  import mtgp_pkg::*;
#(
  parameter int STORE_DEPTH = 128
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_wdata_i,
  mtgp_in_if.sink    in_if,
  mtgp_out_if.source out_if
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int MW = (CW > 7) ? CW : 7;

  // handshake stages
  logic      in_vld_q;
  in_item_t  in_q;
  logic      out_vld_q;
  out_item_t out_q;
  logic      adv;
  logic      proc;
  logic      take;

  // parser state
  parse_state_e state_q, state_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [7:0]    sum_q, sum_d;
  logic [CW-1:0] stamp_off_q, stamp_off_d;
  logic          stamp_vld_q, stamp_vld_d;
  logic [CW-1:0] val_off_q, val_off_d;
  logic          val_vld_q, val_vld_d;
  logic [6:0]    last_q, last_d;
  logic          hist_q;

  logic [6:0] ch;
  logic [6:0] sep;
  logic       is_sep;
  logic       is_start, is_etx, is_cr, is_rx;
  logic       wr_en;
  logic [6:0] wr_data;
  logic [6:0] mem_data;
  logic [7:0] chk;
  logic       frame_done, group_done, group_ok;
  logic [6:0] rdata;
  out_item_t  res;

  assign adv   = !out_vld_q || out_if.ready;
  assign proc  = in_vld_q && adv;
  assign in_if.ready = !in_vld_q || adv;
  assign take  = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q <= in_if.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= 1'b0;
    end else if (cfg_we_i) begin
      hist_q <= cfg_wdata_i;
    end
  end

  // decode of the staged item
  assign ch       = in_q.rx_char[6:0];
  assign sep      = hist_q ? SEP_HIST : SEP_STD;
  assign is_sep   = (ch == sep);
  assign is_rx    = (in_q.opcode == OP_RX);
  assign is_start = is_rx && ((ch == CH_STX) || (ch == CH_LF));
  assign is_etx   = is_rx && (ch == CH_ETX);
  assign is_cr    = is_rx && (ch == CH_CR);
  assign wr_en    = proc && is_rx && !is_start && !is_etx && !is_cr &&
                    (state_q == ST_READ) && (fill_q < CW'(STORE_DEPTH));
  assign wr_data  = is_sep ? 7'd0 : ch;

  mtgp_store #(
    .DEPTH (STORE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (AW'(fill_q)),
    .wr_data_i (wr_data),
    .rd_en_i   (take),
    .rd_addr_i (in_if.data.read_index),
    .rd_data_o (mem_data)
  );

  // next parse state
  always_comb begin
    state_d = state_q;
    if (is_start) begin
      state_d = ST_READ;
    end else if (is_etx) begin
      state_d = ST_WAIT;
    end
  end

  // checksum over the group with the checksum character itself taken out, and in historic mode the last separator too
  assign chk = {2'b00, SUM_MASK & 6'(sum_q - {1'b0, last_q} - (hist_q ? SUM_BIAS : 8'd0))}
               + SUM_BIAS;

  always_comb begin
    fill_d      = fill_q;
    sum_d       = sum_q;
    stamp_off_d = stamp_off_q;
    stamp_vld_d = stamp_vld_q;
    val_off_d   = val_off_q;
    val_vld_d   = val_vld_q;
    last_d      = last_q;
    frame_done  = 1'b0;
    group_done  = 1'b0;
    group_ok    = 1'b0;
    rdata       = 7'd0;
    if (!is_rx) begin
      if (MW'(in_q.read_index) < MW'(fill_q)) begin
        rdata = mem_data;
      end
    end else if (is_start) begin
      fill_d      = '0;
      sum_d       = 8'd0;
      stamp_off_d = '0;
      stamp_vld_d = 1'b0;
      val_off_d   = '0;
      val_vld_d   = 1'b0;
    end else if (is_etx) begin
      frame_done = (state_q == ST_READ);
    end else if (is_cr) begin
      if (state_q == ST_READ) begin
        group_done = 1'b1;
        // empty group or checksum mismatch drops the group
        if ((fill_q == '0) || (chk != {1'b0, last_q})) begin
          fill_d      = '0;
          sum_d       = 8'd0;
          stamp_off_d = '0;
          stamp_vld_d = 1'b0;
          val_off_d   = '0;
          val_vld_d   = 1'b0;
        end else begin
          sum_d    = chk;
          group_ok = 1'b1;
          // no timestamp: the value sits where the stamp was found
          if (val_vld_q && (val_off_q == fill_q - CW'(1))) begin
            val_off_d   = stamp_off_q;
            val_vld_d   = stamp_vld_q;
            stamp_off_d = '0;
            stamp_vld_d = 1'b0;
          end
        end
      end
    end else if (wr_en) begin
      fill_d = fill_q + CW'(1);
      sum_d  = sum_q + {1'b0, ch};
      last_d = wr_data;
      if (is_sep) begin
        if (!stamp_vld_q) begin
          stamp_vld_d = 1'b1;
          stamp_off_d = fill_q + CW'(1);
        end else if (!val_vld_q) begin
          val_vld_d = 1'b1;
          val_off_d = fill_q + CW'(1);
        end
      end
    end
  end

  always_comb begin
    res.link_state    = state_d;
    res.frame_done    = frame_done;
    res.group_done    = group_done;
    res.group_ok      = group_ok;
    res.group_length  = 8'(fill_d);
    res.stamp_present = stamp_vld_d;
    res.stamp_start   = 8'(stamp_off_d);
    res.value_present = val_vld_d;
    res.value_start   = 8'(val_off_d);
    res.read_data     = rdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      fill_q      <= '0;
      sum_q       <= 8'd0;
      stamp_off_q <= '0;
      stamp_vld_q <= 1'b0;
      val_off_q   <= '0;
      val_vld_q   <= 1'b0;
      last_q      <= 7'd0;
    end else if (proc) begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      sum_q       <= sum_d;
      stamp_off_q <= stamp_off_d;
      stamp_vld_q <= stamp_vld_d;
      val_off_q   <= val_off_d;
      val_vld_q   <= val_vld_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc) begin
      out_q <= res;
    end
  end

  assign out_if.valid = out_vld_q;
  assign out_if.data  = out_q;

`ifndef SYNTHESIS
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(STORE_DEPTH))
    else $error("fill count beyond store depth");

  a_ok_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (!out_q.group_ok || out_q.group_done))
    else $error("group ok without group done");

  a_stamp_in_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stamp_vld_q |-> ((stamp_off_q != '0) && (stamp_off_q <= fill_q)))
    else $error("stamp offset outside group");

  a_frame_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.frame_done) |-> (out_q.link_state == ST_WAIT))
    else $error("frame done outside wait state");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !out_if.ready) |-> !in_if.ready)
    else $error("input taken while both stages are full");
`endif

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the meter telemetry group parser. A driver and a
// monitor work from queues: the stimulus is a short directed sequence, then
// random frames of well-formed groups, bad checksums, overlong groups,
// read-backs and raw noise, in both separator modes. Every accepted item is
// run through a behavioral parser and each result is compared by field.
// ----------------------------------------------------------------------------
module testbench;
  import mtgp_pkg::*;

  localparam int STORE_DEPTH   = 128;
  localparam int ITEMS_PER_RUN = 300;
  localparam int HOLD_CYCLES   = 150;
  localparam int DRAIN_CYCLES  = 6;
  localparam int QUIET_LIMIT   = 4000;
  localparam int STAMP_LEN     = 13;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we;
  logic cfg_wdata;

  mtgp_in_if  in_ch ();
  mtgp_out_if out_ch ();

  meter_teleinfo_group_parser DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_if      (in_ch.sink),
    .out_if     (out_ch.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // parser model state
  logic         hist_mode = 1'b0;
  parse_state_e link_st = ST_INIT;
  logic [7:0]   fill_cnt = '0;
  logic [7:0]   sum_acc = '0;
  logic [6:0]   grp_mem [STORE_DEPTH];
  logic [7:0]   stamp_off = '0;
  logic         stamp_ok = 1'b0;
  logic [7:0]   val_off = '0;
  logic         val_ok = 1'b0;

  in_item_t  char_q [$];
  out_item_t status_due_q [$];

  int n_queued = 0;
  int n_taken = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_good_groups = 0;
  int n_bad_groups = 0;
  int n_frames = 0;
  int quiet_cycles = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  logic in_taken = 1'b0;

  function automatic void clear_group();
    fill_cnt  = '0;
    sum_acc   = '0;
    stamp_off = '0;
    stamp_ok  = 1'b0;
    val_off   = '0;
    val_ok    = 1'b0;
  endfunction

  function automatic out_item_t predict_status(in_item_t it);
    out_item_t  r;
    logic [6:0] c;
    logic [6:0] sep;
    logic [6:0] last;
    logic [7:0] s;
    r   = '0;
    c   = it.rx_char[6:0];
    sep = hist_mode ? SEP_HIST : SEP_STD;
    if (opcode_e'(it.opcode) == OP_READ) begin
      if ({1'b0, it.read_index} < fill_cnt) begin
        r.read_data = grp_mem[it.read_index];
      end
    end else if (c == CH_STX || c == CH_LF) begin
      clear_group();
      link_st = ST_READ;
    end else if (c == CH_ETX) begin
      if (link_st == ST_READ) begin
        r.frame_done = 1'b1;
        n_frames++;
      end
      link_st = ST_WAIT;
    end else if (c == CH_CR) begin
      if (link_st == ST_READ) begin
        r.group_done = 1'b1;
        if (fill_cnt == 0) begin
          clear_group();
          n_bad_groups++;
        end else begin
          last = grp_mem[fill_cnt - 8'd1];
          s = sum_acc - {1'b0, last};
          if (hist_mode) begin
            s = s - {1'b0, SEP_HIST};
          end
          s = (s & {2'b00, SUM_MASK}) + SUM_BIAS;
          sum_acc = s;
          if (s != {1'b0, last}) begin
            clear_group();
            n_bad_groups++;
          end else begin
            r.group_ok = 1'b1;
            n_good_groups++;
            // no timestamp: the value sits where the stamp was found
            if (val_ok && val_off == fill_cnt - 8'd1) begin
              val_off   = stamp_off;
              val_ok    = stamp_ok;
              stamp_off = '0;
              stamp_ok  = 1'b0;
            end
          end
        end
      end
    end else if (link_st == ST_READ && fill_cnt < STORE_DEPTH) begin
      grp_mem[fill_cnt[6:0]] = (c == sep) ? 7'd0 : c;
      fill_cnt = fill_cnt + 8'd1;
      if (c == sep) begin
        if (!stamp_ok) begin
          stamp_ok  = 1'b1;
          stamp_off = fill_cnt;
        end else if (!val_ok) begin
          val_ok  = 1'b1;
          val_off = fill_cnt;
        end
      end
      sum_acc = sum_acc + {1'b0, c};
    end
    r.link_state    = link_st;
    r.group_length  = fill_cnt;
    r.stamp_present = stamp_ok;
    r.stamp_start   = stamp_off;
    r.value_present = val_ok;
    r.value_start   = val_off;
    return r;
  endfunction

  task automatic report(string field, int got, int want);
    if (n_errors < 40) begin
      $display("mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
               field, n_results, got, want);
    end
    n_errors++;
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_item(opcode_e op, logic [7:0] c, logic [6:0] idx);
    in_item_t it;
    it.opcode     = op;
    it.rx_char    = c;
    it.read_index = idx;
    char_q.push_back(it);
    n_queued++;
  endtask

  task automatic push_rx(logic [7:0] c);
    push_item(OP_RX, c, 7'($urandom));
  endtask

  task automatic push_read(logic [6:0] idx);
    push_item(OP_READ, 8'($urandom), idx);
  endtask

  function automatic logic [7:0] rand_text();
    return {1'($urandom), 7'($urandom_range(8'h21, 8'h7E))};
  endfunction

  // LF label SEP [stamp SEP] value SEP checksum CR
  task automatic add_group(logic hist, logic with_stamp, logic corrupt, int label_len,
                           int val_len);
    logic [7:0] sum;
    logic [7:0] ch;
    logic [6:0] sep;
    logic [6:0] chk;
    sum = '0;
    sep = hist ? SEP_HIST : SEP_STD;
    push_rx({1'($urandom), CH_LF});
    for (int i = 0; i < label_len; i++) begin
      ch = rand_text();
      push_rx(ch);
      sum += {1'b0, ch[6:0]};
    end
    push_rx({1'($urandom), sep});
    sum += {1'b0, sep};
    if (with_stamp) begin
      for (int i = 0; i < STAMP_LEN; i++) begin
        ch = rand_text();
        push_rx(ch);
        sum += {1'b0, ch[6:0]};
      end
      push_rx({1'($urandom), sep});
      sum += {1'b0, sep};
    end
    for (int i = 0; i < val_len; i++) begin
      ch = rand_text();
      push_rx(ch);
      sum += {1'b0, ch[6:0]};
    end
    push_rx({1'($urandom), sep});
    sum += {1'b0, sep};
    // historic checksum leaves out the last separator
    if (hist) begin
      sum -= {1'b0, SEP_HIST};
    end
    chk = {1'b0, sum[5:0]} + SUM_BIAS[6:0];
    if (corrupt) begin
      chk = (chk == 7'h5F) ? 7'h21 : chk + 7'd1;
    end
    push_rx({1'($urandom), chk});
    push_rx({1'($urandom), CH_CR});
  endtask

  task automatic add_random(logic hist, int count);
    int base;
    int pick;
    int len;
    base = n_queued;
    while (n_queued - base < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        push_rx({1'($urandom), CH_STX});
        repeat ($urandom_range(1, 4)) begin
          add_group(hist, $urandom_range(0, 99) < 40, $urandom_range(0, 99) < 12,
                    $urandom_range(1, 8), $urandom_range(0, 12));
          if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) push_read(7'($urandom_range(0, 40)));
          end
        end
        if ($urandom_range(0, 9) != 0) begin
          push_rx({1'($urandom), CH_ETX});
        end
      end else if (pick < 64) begin
        // overlong group runs into the end of the store
        push_rx({1'b0, CH_LF});
        len = $urandom_range(STORE_DEPTH - 4, STORE_DEPTH + 12);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(0, 19) == 0) begin
            push_rx({1'b0, hist ? SEP_HIST : SEP_STD});
          end else begin
            push_rx(rand_text());
          end
        end
        push_read(7'($urandom_range(STORE_DEPTH - 8, STORE_DEPTH - 1)));
        push_rx({1'b0, CH_CR});
      end else if (pick < 80) begin
        push_read(7'($urandom));
      end else begin
        push_rx(8'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (char_q.size() != 0 || n_taken != n_queued || status_due_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_mode(logic hist);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= hist;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    hist_mode = hist;
  endtask

  // ------------------------------------------------------------------ driver

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (char_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= char_q.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // ----------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        status_due_q.push_back(predict_status(in_ch.data));
        n_taken++;
      end
      if (out_ch.valid && out_ch.ready) begin
        n_results++;
        got = out_ch.data;
        if (status_due_q.size() == 0) begin
          report("unexpected transfer", 1, 0);
        end else begin
          want = status_due_q.pop_front();
          if (got.link_state !== want.link_state)
            report("link_state", got.link_state, want.link_state);
          if (got.frame_done !== want.frame_done)
            report("frame_done", got.frame_done, want.frame_done);
          if (got.group_done !== want.group_done)
            report("group_done", got.group_done, want.group_done);
          if (got.group_ok !== want.group_ok)
            report("group_ok", got.group_ok, want.group_ok);
          if (got.group_length !== want.group_length)
            report("group_length", got.group_length, want.group_length);
          if (got.stamp_present !== want.stamp_present)
            report("stamp_present", got.stamp_present, want.stamp_present);
          if (got.stamp_start !== want.stamp_start)
            report("stamp_start", got.stamp_start, want.stamp_start);
          if (got.value_present !== want.value_present)
            report("value_present", got.value_present, want.value_present);
          if (got.value_start !== want.value_start)
            report("value_start", got.value_start, want.value_start);
          if (got.read_data !== want.read_data)
            report("read_data", got.read_data, want.read_data);
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, status_due_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    logic run_hist [4];
    int   run_src [4];
    int   run_snk [4];
    run_hist = '{1'b0, 1'b1, 1'b1, 1'b0};
    run_src  = '{8, 62, 0, 0};
    run_snk  = '{62, 8, 0, 0};
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_mode(1'b0);
    src_idle_pct = run_src[0];
    snk_idle_pct = run_snk[0];
    // reads and control characters before any frame has started
    push_read(7'h7F);
    push_read(7'h00);
    push_rx({1'b0, CH_CR});
    push_rx(8'hC1);
    push_rx({1'b0, CH_ETX});
    push_rx({1'b1, CH_STX});
    push_rx({1'b0, CH_CR});          // checksum on an empty group
    add_group(1'b0, 1'b0, 1'b0, 1, 0);
    push_read(7'd1);
    push_read(7'd3);
    push_read(7'd4);
    add_group(1'b0, 1'b0, 1'b1, 1, 1);
    push_rx(8'hFF);
    push_rx(8'h80);
    push_rx({1'b0, CH_ETX});
    push_rx({1'b0, CH_CR});          // ignored while waiting for a start
    push_rx(8'h41);
    wait_drained();

    for (int run = 0; run < 4; run++) begin
      write_mode(run_hist[run]);
      src_idle_pct = run_src[run];
      snk_idle_pct = run_snk[run];
      add_random(run_hist[run], ITEMS_PER_RUN);
      if (run == 2) begin
        hold_req = ~hold_req;
      end
      wait_drained();
    end

    $display("%0d items sent, %0d results checked in tab and space separator modes",
             n_taken, n_results);
    $display("%0d groups passed checksum, %0d failed, %0d frames closed",
             n_good_groups, n_bad_groups, n_frames);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
